// ===== rtl/core/pillar_weighted_accumulate_requant_unit_assert.svh =====
// Assertion macros used by the unit's top-level RTL file.
`ifndef PILLAR_WEIGHTED_ACCUMULATE_REQUANT_UNIT_ASSERT_SVH
`define PILLAR_WEIGHTED_ACCUMULATE_REQUANT_UNIT_ASSERT_SVH

// antecedent in any cycle implies consequent in the next
`define PWAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

// condition must never hold
`define PWAR_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        !(cond)) else $error("assertion failed");

`endif

// ===== rtl/core/pwar_pkg.sv =====
package pwar_pkg;

    localparam int LANES      = 8;
    localparam int MAX_LANES  = 8;
    localparam int FEAT_W     = 8 * MAX_LANES;
    localparam int WEIGHT_W   = 8;
    localparam int LANE_W     = 8;
    localparam int CONTRIB_W  = WEIGHT_W + LANE_W + 1;
    localparam int SUM_W      = 32;
    localparam int SCALE_W    = 24;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = SUM_W + SCALE_W;
    localparam int Q_W        = PROD_W - FRAC_BITS;
    localparam int CELL_W     = 14;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 80;
    localparam int ADDR_W     = 3;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);
    localparam logic [0:0] REG_SCALE = 1'b0;

    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'(127);
    localparam logic signed [Q_W-1:0] SAT_LO = -(Q_W'(128));

    typedef struct packed {
        logic acc_en;
        logic cap;
    } t_lane_ctrl;

    typedef struct packed {
        logic load;
        logic take;
    } t_out_ctrl;

    function automatic logic [LANE_W-1:0] sat_lane(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] sh;
        logic signed [Q_W-1:0]    q;
        sh = p >>> FRAC_BITS;
        q  = sh[Q_W-1:0];
        if (q > SAT_HI) begin
            return SAT_HI[LANE_W-1:0];
        end else if (q < SAT_LO) begin
            return SAT_LO[LANE_W-1:0];
        end else begin
            return q[LANE_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/core/pillar_weighted_accumulate_requant_unit.sv =====
// Channel   Dir  Payload (low bit up)                                  Marks
// s_axis    in   tdata: depth_weight[7:0] feature_word[71:8]           tuser: point_present
//                       cell_index[85:72], zero pad to 88              tlast: pillar_last
// m_axis    out  tdata: cell_out[13:0] packed_result[77:14], pad to 80 -
// apb       in   0x0: requant_scale (24 bits signed, sign-extended on read)
//
// A point item is accepted every cycle while no closed pillar waits for capture; the
// eight lanes accumulate it. A pillar-closing item is followed by a capture, in which
// the lane multipliers take the sums; a new item is taken in that cycle unless the
// product stage is still full. Results pass from the product stage to the output
// register; a stalled output holds the product stage and then the input. Reset is
// synchronous and clears the sums and all valid flags; the scale returns to 1.0.
module pillar_weighted_accumulate_requant_unit
    import pwar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // depth_weight, feature_word, cell_index
    input  logic                  s_axis_tuser,   // point_present
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cell_out, packed_result
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    `include "pillar_weighted_accumulate_requant_unit_assert.svh"

    logic [SCALE_W-1:0]  r_scale;
    logic                r_cl;
    logic [CELL_W-1:0]   r_cell;
    logic                r_p_valid;
    logic [CELL_W-1:0]   r_p_cell;
    logic                w_s_acc;
    logic                w_cap;
    logic                w_o_load;
    logic                w_o_valid;
    logic [WEIGHT_W-1:0] w_weight;
    logic [FEAT_W-1:0]   w_feat;
    logic [PROD_W-1:0]   w_prod [LANES];
    t_lane_ctrl          w_lane_ctrl;
    t_out_ctrl           w_out_ctrl;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SCALE)) begin
            r_scale <= pwdata[SCALE_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_SCALE)
                  ? {{(32-SCALE_W){r_scale[SCALE_W-1]}}, r_scale} : '0;

    assign w_weight = s_axis_tdata[WEIGHT_W-1:0];
    assign w_feat   = s_axis_tdata[WEIGHT_W +: FEAT_W];

    assign w_o_load      = r_p_valid && (!w_o_valid || m_axis_tready);
    assign w_cap         = r_cl && (!r_p_valid || w_o_load);
    assign s_axis_tready = !r_cl || w_cap;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    assign w_lane_ctrl.acc_en = w_s_acc && s_axis_tuser;
    assign w_lane_ctrl.cap    = w_cap;
    assign w_out_ctrl.load    = w_o_load;
    assign w_out_ctrl.take    = w_o_valid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl      <= 1'b0;
            r_p_valid <= 1'b0;
        end else begin
            if (w_s_acc && s_axis_tlast) begin
                r_cl <= 1'b1;
            end else if (w_cap) begin
                r_cl <= 1'b0;
            end
            if (w_cap) begin
                r_p_valid <= 1'b1;
            end else if (w_o_load) begin
                r_p_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && s_axis_tlast) begin
            r_cell <= s_axis_tdata[WEIGHT_W+FEAT_W +: CELL_W];
        end
        if (w_cap) begin
            r_p_cell <= r_cell;
        end
    end

    for (genvar c = 0; c < LANES; c++) begin : g_lane
        pwar_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_lane_ctrl),
            .i_weight (w_weight),
            .i_feat   (w_feat[LANE_W*c +: LANE_W]),
            .i_scale  (r_scale),
            .o_prod   (w_prod[c])
        );
    end

    pwar_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_out_ctrl),
        .i_prod  (w_prod),
        .i_cell  (r_p_cell),
        .o_valid (w_o_valid),
        .o_data  (m_axis_tdata)
    );

    assign m_axis_tvalid = w_o_valid;

    `PWAR_ASSERT_NEXT(a_last_sets_close, w_s_acc && s_axis_tlast, r_cl)
    `PWAR_ASSERT_NEXT(a_cap_fills_prod, w_cap, r_p_valid)
    `PWAR_ASSERT_NEXT(a_prod_holds, r_p_valid && !w_o_load, r_p_valid)
    `PWAR_ASSERT_NEVER(a_no_prod_overwrite, w_cap && r_p_valid && !w_o_load)

endmodule

// ===== rtl/core/pwar_lane.sv =====
module pwar_lane
    import pwar_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_lane_ctrl                i_ctrl,
    input  logic [WEIGHT_W-1:0]       i_weight,
    input  logic [LANE_W-1:0]         i_feat,
    input  logic [SCALE_W-1:0]        i_scale,
    output logic [PROD_W-1:0]         o_prod
);

    logic [SUM_W-1:0]          r_sum;
    logic [SUM_W-1:0]          n_sum;
    logic [PROD_W-1:0]         r_prod;
    logic signed [WEIGHT_W:0]  w_weight;
    logic signed [LANE_W-1:0]  w_feat;
    logic signed [CONTRIB_W-1:0] w_contrib;
    logic signed [SUM_W-1:0]   w_sum_s;
    logic signed [SCALE_W-1:0] w_scale_s;
    logic signed [PROD_W-1:0]  w_mul;
    logic [SUM_W-1:0]          w_base;

    assign w_weight  = $signed({1'b0, i_weight});
    assign w_feat    = $signed(i_feat);
    assign w_contrib = w_weight * w_feat;
    assign w_base    = i_ctrl.cap ? '0 : r_sum;

    always_comb begin
        n_sum = w_base;
        if (i_ctrl.acc_en) begin
            n_sum = w_base + {{(SUM_W-CONTRIB_W){w_contrib[CONTRIB_W-1]}}, w_contrib};
        end
    end

    assign w_sum_s   = $signed(r_sum);
    assign w_scale_s = $signed(i_scale);
    assign w_mul     = w_sum_s * w_scale_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            r_prod <= w_mul;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/pwar_merge.sv =====
module pwar_merge
    import pwar_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_out_ctrl             i_ctrl,
    input  logic [PROD_W-1:0]     i_prod [LANES],
    input  logic [CELL_W-1:0]     i_cell,
    output logic                  o_valid,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic [FEAT_W-1:0]     w_packed;
    logic                  r_valid;
    logic [FEAT_W-1:0]     r_packed;
    logic [CELL_W-1:0]     r_cell;

    for (genvar c = 0; c < MAX_LANES; c++) begin : g_pack
        if (c < LANES) begin : g_on
            assign w_packed[LANE_W*c +: LANE_W] = sat_lane($signed(i_prod[c]));
        end else begin : g_off
            assign w_packed[LANE_W*c +: LANE_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctrl.take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_packed <= w_packed;
            r_cell   <= i_cell;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(OUT_DATA_W-FEAT_W-CELL_W){1'b0}}, r_packed, r_cell};

endmodule

// ===== dv/tb.sv =====
module tb;
    import pwar_pkg::*;

    localparam int CYCLE_LIMIT  = 40000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_POINTS  = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [ADDR_W-1:0] SCALE_ADDR = ADDR_W'(4 * REG_SCALE);

    typedef struct packed {
        logic [CELL_W-1:0] cell_idx;
        logic [FEAT_W-1:0] word;
    } t_pillar_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // depth_weight, feature_word, cell_index
    logic                  s_axis_tuser = 1'b0; // point_present
    logic                  s_axis_tlast = 1'b0; // pillar_last
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // cell_out, packed_result
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic [SUM_W-1:0]   lane_acc [LANES] = '{default: '0};
    logic [SCALE_W-1:0] cur_scale = SCALE_RESET;
    t_pillar_word       pending_pillars [$];

    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int sink_hold    = 0;

    int cycle_count    = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int scales_written = 0;
    int mismatch_count = 0;

    pillar_weighted_accumulate_requant_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pillar words outstanding",
                     cycle_count, pending_pillars.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] exp_val,
                                   input logic [63:0] got_val);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d: %s expected %h got %h",
                     cycle_count, what, exp_val, got_val);
        end
    endtask

    function automatic void accumulate_point(input logic [WEIGHT_W-1:0] w,
                                             input logic [FEAT_W-1:0] feat);
        logic signed [CONTRIB_W-1:0] contrib;
        for (int c = 0; c < LANES; c++) begin
            contrib = $signed({1'b0, w}) * $signed(feat[8*c +: 8]);
            lane_acc[c] = lane_acc[c] + {{(SUM_W-CONTRIB_W){contrib[CONTRIB_W-1]}}, contrib};
        end
    endfunction

    function automatic logic [LANE_W-1:0] requant_lane(input logic [SUM_W-1:0] acc);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] floored;
        prod = $signed({{SCALE_W{acc[SUM_W-1]}}, acc})
             * $signed({{SUM_W{cur_scale[SCALE_W-1]}}, cur_scale});
        floored = prod >>> FRAC_BITS;
        if (floored > 127) begin
            return LANE_W'(127);
        end else if (floored < -128) begin
            return LANE_W'(-128);
        end else begin
            return floored[LANE_W-1:0];
        end
    endfunction

    function automatic void close_pillar(input logic [CELL_W-1:0] cell_idx);
        t_pillar_word res;
        res.cell_idx = cell_idx;
        res.word = '0;
        for (int c = 0; c < LANES; c++) begin
            res.word[8*c +: 8] = requant_lane(lane_acc[c]);
            lane_acc[c] = '0;
        end
        pending_pillars.push_back(res);
    endfunction

    task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [FEAT_W-1:0] feat,
                             input logic present, input logic last,
                             input logic [CELL_W-1:0] cell_idx);
        @(negedge i_clk);
        if (src_idle_on && $urandom_range(99) < 26) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_DATA_W'({cell_idx, feat, w});
        s_axis_tuser  = present;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (present) accumulate_point(w, feat);
        if (last) close_pillar(cell_idx);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_pillars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = SCALE_ADDR;
        pwdata  = {{(32-SCALE_W){value[SCALE_W-1]}}, value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        cur_scale = value;
        scales_written++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_scale();
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = SCALE_ADDR;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== {{(32-SCALE_W){cur_scale[SCALE_W-1]}}, cur_scale}) begin
            report_mismatch("requant_scale readback",
                            64'({{(32-SCALE_W){cur_scale[SCALE_W-1]}}, cur_scale}), 64'(got));
        end
    endtask

    // Output checker
    always @(posedge i_clk) begin : check_output
        t_pillar_word exp_word;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_pillars.size() == 0) begin
                report_mismatch("unexpected pillar word", '0, 64'(m_axis_tdata[CELL_W +: FEAT_W]));
            end else begin
                exp_word = pending_pillars.pop_front();
                if (m_axis_tdata[CELL_W-1:0] !== exp_word.cell_idx) begin
                    report_mismatch("cell_out", 64'(exp_word.cell_idx),
                                    64'(m_axis_tdata[CELL_W-1:0]));
                end
                if (m_axis_tdata[CELL_W +: FEAT_W] !== exp_word.word) begin
                    report_mismatch("packed_result", exp_word.word,
                                    m_axis_tdata[CELL_W +: FEAT_W]);
                end
            end
        end
    end

    // Output backpressure
    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            m_axis_tready = 1'b0;
            sink_hold = sink_hold - 1;
        end else if (sink_idle_on) begin
            m_axis_tready = ($urandom_range(99) >= 26);
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return '1;
        if (sel < 25) return '0;
        if (sel < 35) return WEIGHT_W'($urandom_range(3, 1));
        return WEIGHT_W'($urandom);
    endfunction

    function automatic logic [FEAT_W-1:0] pick_features();
        logic [FEAT_W-1:0] feat;
        logic [7:0]        corner [4] = '{8'h80, 8'h7F, 8'h00, 8'hFF};
        if ($urandom_range(99) < 20) begin
            for (int c = 0; c < 8; c++) feat[8*c +: 8] = corner[$urandom_range(3)];
        end else begin
            feat = {$urandom, $urandom};
        end
        return feat;
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5) return '0;
        if (sel < 10) return '1;
        return CELL_W'($urandom);
    endfunction

    task automatic send_random_pillar();
        int  points;
        bit  empty_close;
        logic [CELL_W-1:0] cell_idx;
        points = ($urandom_range(99) < 10) ? 0
               : ($urandom_range(99) < 5) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        empty_close = (points == 0) || ($urandom_range(99) < 20);
        cell_idx = pick_cell();
        for (int i = 0; i < points; i++) begin
            if ($urandom_range(99) < 15) begin
                send_item(pick_weight(), pick_features(), 1'b0, 1'b0, pick_cell());
            end
            send_item(pick_weight(), pick_features(), 1'b1,
                      (i == points - 1) && !empty_close, cell_idx);
        end
        if (empty_close) begin
            send_item(pick_weight(), pick_features(), 1'b0, 1'b1, cell_idx);
        end
    endtask

    task automatic run_random_phase(input logic [SCALE_W-1:0] scale);
        int stop_at;
        write_scale(scale);
        check_scale();
        stop_at = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at) send_random_pillar();
        wait_drained();
    endtask

    task automatic test_reset_scale();
        check_scale();
    endtask

    task automatic test_directed_pillars();
        // empty pillars, junk on an ignored item
        send_item('0, '0, 1'b0, 1'b1, '0);
        send_item('1, '1, 1'b0, 1'b0, '0);
        send_item('1, '1, 1'b0, 1'b1, '1);
        // extremes at unit scale
        send_item('1, {8{8'h80}}, 1'b1, 1'b1, '1);
        send_item('1, {8{8'h7F}}, 1'b1, 1'b1, CELL_W'(14'h2AAA));
        send_item('0, 64'hA5C3_9F01_7E80_FF11, 1'b1, 1'b1, CELL_W'(14'h1555));
        send_item(8'd1, 64'h55FE_0200_807F_FF01, 1'b1, 1'b1, CELL_W'(14'h0001));
        // multi-point pillar closed by an empty item
        send_item(8'd1, 64'h0102_0304_F0E0_D0C0, 1'b1, 1'b0, '0);
        send_item(8'd2, 64'h0505_0505_FBFB_FBFB, 1'b1, 1'b0, '0);
        send_item(8'd128, '1, 1'b0, 1'b1, CELL_W'(14'h2000));
        send_item(8'd128, '1, 1'b1, 1'b1, CELL_W'(14'h0100));
        wait_drained();
        // floor toward minus infinity
        write_scale(SCALE_W'(1));
        send_item(8'd1, '1, 1'b1, 1'b1, CELL_W'(14'h0002));
        send_item('1, {8{8'h7F}}, 1'b1, 1'b1, CELL_W'(14'h0003));
        wait_drained();
        write_scale('1);
        send_item(8'd1, '1, 1'b1, 1'b1, CELL_W'(14'h0004));
        send_item('1, {8{8'h7F}}, 1'b1, 1'b1, CELL_W'(14'h0005));
        wait_drained();
        write_scale(SCALE_W'(32768));
        send_item(8'd1, 64'hFF01_FF01_FF03_FFFD, 1'b1, 1'b1, CELL_W'(14'h0006));
        wait_drained();
    endtask

    task automatic test_scale_sweep();
        logic [SCALE_W-1:0] sweep [7];
        logic signed [31:0] r;
        sweep = '{SCALE_RESET, '0, SCALE_W'(1), '1, SCALE_W'(24'h7FFFFF),
                  SCALE_W'(24'h800000), SCALE_W'(24'h000400)};
        for (int p = 0; p < 7; p++) begin
            src_idle_on  = (p != 2);
            sink_idle_on = (p != 2);
            run_random_phase(sweep[p]);
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int p = 0; p < 5; p++) begin
            r = $urandom;
            r = r >>> $urandom_range(31, 8);
            run_random_phase(r[SCALE_W-1:0]);
        end
    endtask

    task automatic test_output_backpressure();
        write_scale(SCALE_W'(24'h000800));
        src_idle_on = 1'b0;
        @(negedge i_clk);
        sink_hold = HOLD_CYCLES;
        for (int i = 0; i < 60; i++) begin
            send_item(pick_weight(), pick_features(), 1'b1, ($urandom_range(3) != 0),
                      pick_cell());
        end
        send_item(pick_weight(), pick_features(), 1'b0, 1'b1, pick_cell());
        wait_drained();
        src_idle_on = 1'b1;
    endtask

    task automatic test_long_pillar();
        write_scale(SCALE_W'(1));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        for (int i = 0; i < LONG_POINTS; i++) begin
            send_item('1, {4{8'h7F, 8'h80}}, 1'b1, (i == LONG_POINTS - 1), CELL_W'(14'h3ABC));
        end
        wait_drained();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_scale();
        test_directed_pillars();
        test_scale_sweep();
        test_output_backpressure();
        test_long_pillar();
        wait_drained();
        $display("run covered %0d items and %0d pillar words over %0d scale settings",
                 items_sent, results_seen, scales_written);
        $display("includes a long output stall and a %0d-point pillar; %0d mismatches",
                 LONG_POINTS, mismatch_count);
        if (mismatch_count == 0 && pending_pillars.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
